// ===== hw/rtl/wpp_pkg.sv =====
// Shared types and constants of the WAV PCM stream parser.
// No dependencies; RTL modules and wpp_result_if use scoped names; the bench imports it.
package wpp_pkg;

    // Four-character tags as they arrive, first byte in the top lane
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] RATE_RESET = 32'd16000;
    localparam logic [15:0] FORMAT_PCM = 16'd1;
    localparam logic [15:0] MONO       = 16'd1;
    localparam logic [15:0] BITS_16    = 16'd16;
    localparam logic [31:0] FMT_BODY   = 32'd16;

    // Result queue: entries hold the one or two results of one byte; depth is a power of two
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_RIFF  = 3'd1,
        ST_NOT_WAVE  = 3'd2,
        ST_MISSING   = 3'd3,
        ST_NOT_PCM   = 3'd4,
        ST_NOT_MONO  = 3'd5,
        ST_BAD_RATE  = 3'd6,
        ST_NOT_16BIT = 3'd7
    } t_status;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              result_kind;
        logic signed [15:0] sample_value;
        t_status            status_code;
        logic               last_result;
    } t_result;

    // One queue entry: count of valid results, r0 delivered before r1
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_pair;

endpackage

// ===== hw/rtl/wpp_byte_if.sv =====
// Input byte channel of the WAV PCM stream parser: valid/ready plus one file byte.
// No dependencies.
interface wpp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

// ===== hw/rtl/wpp_result_if.sv =====
// Result channel of the WAV PCM stream parser: valid/ready plus one sample or status.
// Depends on wpp_pkg for the field types.
interface wpp_result_if;
    logic                 valid;
    logic                 ready;
    wpp_pkg::t_kind       result_kind;
    logic signed [15:0]   sample_value;
    wpp_pkg::t_status     status_code;
    logic                 last_result;

    modport source (output valid, output result_kind, output sample_value,
                    output status_code, output last_result, input ready);
    modport sink   (input valid, input result_kind, input sample_value,
                    input status_code, input last_result, output ready);
endinterface

// ===== hw/rtl/wpp_cfg_if.sv =====
// Configuration write channel of the WAV PCM stream parser: valid/ready plus the rate word.
// No dependencies.
interface wpp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] wr_data;

    modport source (output valid, output wr_data, input ready);
    modport sink   (input valid, input wr_data, output ready);
endinterface

// ===== hw/rtl/wav_pcm_stream_parser.sv =====
// WAV PCM stream parser: one file byte per beat in, at most one sample or status per beat out.
// It accepts a byte every cycle while the four-entry result queue holds two pairs or fewer;
// a byte is parsed in the cycle after its beat, from the input register, and its results
// are offered once they reach the head of the queue. A byte yielding both a last sample
// and the final status hands them out as two results, sample first. The required-rate
// register resets to 16000; the configuration channel writes it and is always ready.
// Depends on wpp_pkg, the three channel interfaces, wpp_parser and wpp_out_queue.
module wav_pcm_stream_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wpp_cfg_if.sink       i_cfg,
    wpp_byte_if.sink      i_in,
    wpp_result_if.source  o_out
);

    logic [31:0]     r_required_rate;
    logic            space_ok;
    logic            push;
    wpp_pkg::t_pair  pair;

    // Hold the required sample rate
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_required_rate <= wpp_pkg::RATE_RESET;
        end else if (i_cfg.valid) begin
            r_required_rate <= i_cfg.wr_data;
        end
    end

    wpp_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (i_in),
        .i_space_ok      (space_ok),
        .i_required_rate (r_required_rate),
        .o_push          (push),
        .o_pair          (pair)
    );

    wpp_out_queue u_out_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pair     (pair),
        .o_out      (o_out),
        .o_space_ok (space_ok)
    );

endmodule

// ===== hw/rtl/wpp_parser.sv =====
// Byte parser: input register, RIFF/WAVE chunk walker state and result pair generation.
// Depends on wpp_pkg and wpp_byte_if.
module wpp_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    wpp_byte_if.sink            i_in,
    input  logic                i_space_ok,
    input  logic [31:0]         i_required_rate,
    output logic                o_push,
    output wpp_pkg::t_pair      o_pair
);

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_CHUNK  = 6'b000010,
        PH_FMT    = 6'b000100,
        PH_EXCESS = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_SKIP   = 6'b100000
    } t_phase;

    // Final verdict of a file in priority order; a missing fmt or data chunk ranks first
    function automatic wpp_pkg::t_status final_code(
        input logic        fmt_present,
        input logic        data_present,
        input logic [15:0] fmt_tag,
        input logic [15:0] channels,
        input logic [31:0] rate,
        input logic [31:0] required,
        input logic [15:0] bits
    );
        if (!fmt_present || !data_present) return wpp_pkg::ST_MISSING;
        if (fmt_tag != wpp_pkg::FORMAT_PCM) return wpp_pkg::ST_NOT_PCM;
        if (channels != wpp_pkg::MONO) return wpp_pkg::ST_NOT_MONO;
        if (rate != required) return wpp_pkg::ST_BAD_RATE;
        if (bits != wpp_pkg::BITS_16) return wpp_pkg::ST_NOT_16BIT;
        return wpp_pkg::ST_OK;
    endfunction

    // Input register
    logic        r_beat_valid;
    logic [7:0]  r_byte;
    logic        r_eof;

    // Parser state
    t_phase      r_phase,        n_phase;
    logic [3:0]  r_byte_index,   n_byte_index;
    logic [31:0] r_tag_shift,    n_tag_shift;
    logic [31:0] r_chunk_length, n_chunk_length;
    logic [32:0] r_bytes_left,   n_bytes_left;
    logic [15:0] r_format_tag,   n_format_tag;
    logic [15:0] r_channels,     n_channels;
    logic [31:0] r_rate,         n_rate;
    logic [15:0] r_bits,         n_bits;
    logic        r_fmt_found,    n_fmt_found;
    logic        r_data_found,   n_data_found;
    logic [7:0]  r_low_byte,     n_low_byte;
    logic        r_finished,     n_finished;

    logic              emit_sample;
    logic              emit_status;
    wpp_pkg::t_status  status_code;
    logic              accept;

    assign i_in.ready = i_space_ok;
    assign accept     = i_in.valid && i_space_ok;

    // Capture the accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat_valid <= 1'b0;
        end else begin
            r_beat_valid <= accept;
        end
        if (accept) begin
            r_byte <= i_in.data_byte;
            r_eof  <= i_in.end_of_file;
        end
    end

    // Next state for the registered byte
    always_comb begin : p_next
        logic [31:0] tag_new;
        logic [31:0] len_new;
        logic        done;

        n_phase        = r_phase;
        n_byte_index   = r_byte_index;
        n_tag_shift    = r_tag_shift;
        n_chunk_length = r_chunk_length;
        n_bytes_left   = r_bytes_left;
        n_format_tag   = r_format_tag;
        n_channels     = r_channels;
        n_rate         = r_rate;
        n_bits         = r_bits;
        n_fmt_found    = r_fmt_found;
        n_data_found   = r_data_found;
        n_low_byte     = r_low_byte;
        n_finished     = r_finished;
        emit_sample    = 1'b0;
        emit_status    = 1'b0;
        status_code    = wpp_pkg::ST_OK;
        done           = 1'b0;
        tag_new        = {r_tag_shift[23:0], r_byte};
        len_new        = {r_byte, r_chunk_length[31:8]};

        if (r_beat_valid && !r_finished) begin
            case (r_phase)
                // File header: RIFF tag, ignored size, WAVE tag
                PH_HEADER: begin
                    n_tag_shift = tag_new;
                    if (r_byte_index == 4'd3 && tag_new != wpp_pkg::TAG_RIFF) begin
                        emit_status = 1'b1;
                        status_code = wpp_pkg::ST_NOT_RIFF;
                    end else if (r_byte_index == 4'd11) begin
                        if (tag_new != wpp_pkg::TAG_WAVE) begin
                            emit_status = 1'b1;
                            status_code = wpp_pkg::ST_NOT_WAVE;
                        end else begin
                            n_phase      = PH_CHUNK;
                            n_byte_index = 4'd0;
                        end
                    end else begin
                        n_byte_index = r_byte_index + 4'd1;
                    end
                end
                // Chunk header: id, then little-endian size
                PH_CHUNK: begin
                    if (r_byte_index < 4'd4) begin
                        n_tag_shift  = tag_new;
                        n_byte_index = r_byte_index + 4'd1;
                    end else begin
                        n_chunk_length = len_new;
                        if (r_byte_index < 4'd7) begin
                            n_byte_index = r_byte_index + 4'd1;
                        end else begin
                            n_byte_index = 4'd0;
                            if (r_tag_shift == wpp_pkg::TAG_FMT) begin
                                n_fmt_found = 1'b1;
                                n_phase     = PH_FMT;
                            end else if (r_tag_shift == wpp_pkg::TAG_DATA) begin
                                n_data_found = 1'b1;
                                n_bytes_left = {1'b0, len_new[31:1], 1'b0};
                                if (len_new[31:1] == 31'd0) begin
                                    done = 1'b1;
                                end else begin
                                    n_phase = PH_DATA;
                                end
                            end else begin
                                // skip body plus pad byte on odd sizes
                                n_bytes_left = {1'b0, len_new} + {32'd0, len_new[0]};
                                if (len_new == 32'd0) begin
                                    done = 1'b1;
                                end else begin
                                    n_phase = PH_SKIP;
                                end
                            end
                        end
                    end
                end
                // fmt body: capture fields by byte lane
                PH_FMT: begin
                    case (r_byte_index)
                        4'd0:    n_format_tag[7:0]  = r_byte;
                        4'd1:    n_format_tag[15:8] = r_byte;
                        4'd2:    n_channels[7:0]    = r_byte;
                        4'd3:    n_channels[15:8]   = r_byte;
                        4'd4:    n_rate[7:0]        = r_byte;
                        4'd5:    n_rate[15:8]       = r_byte;
                        4'd6:    n_rate[23:16]      = r_byte;
                        4'd7:    n_rate[31:24]      = r_byte;
                        4'd14:   n_bits[7:0]        = r_byte;
                        4'd15:   n_bits[15:8]       = r_byte;
                        default: ;
                    endcase
                    if (r_byte_index != 4'd15) begin
                        n_byte_index = r_byte_index + 4'd1;
                    end else begin
                        n_byte_index = 4'd0;
                        if (r_chunk_length > wpp_pkg::FMT_BODY) begin
                            n_bytes_left = {1'b0, r_chunk_length - wpp_pkg::FMT_BODY};
                            n_phase      = PH_EXCESS;
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
                // data body: pair bytes into samples; Q1.15 of raw/32768 is the raw word
                PH_DATA: begin
                    if (!r_byte_index[0]) begin
                        n_low_byte   = r_byte;
                        n_byte_index = 4'd1;
                    end else begin
                        emit_sample  = 1'b1;
                        n_byte_index = 4'd0;
                    end
                    if (r_bytes_left != 33'd0) n_bytes_left = r_bytes_left - 33'd1;
                    if (r_bytes_left <= 33'd1) done = 1'b1;
                end
                // fmt excess and foreign chunks: drop bytes
                PH_EXCESS, PH_SKIP: begin
                    if (r_bytes_left != 33'd0) n_bytes_left = r_bytes_left - 33'd1;
                    if (r_bytes_left <= 33'd1) done = 1'b1;
                end
                default: ;
            endcase

            // Chunk complete: close the file or go to the next chunk header
            if (done) begin
                if (n_fmt_found && n_data_found) begin
                    emit_status = 1'b1;
                    status_code = final_code(n_fmt_found, n_data_found, n_format_tag,
                                             n_channels, n_rate, i_required_rate, n_bits);
                end else begin
                    n_phase      = PH_CHUNK;
                    n_byte_index = 4'd0;
                end
            end

            // End of file before a verdict
            if (r_eof && !emit_status) begin
                emit_status = 1'b1;
                if (n_phase == PH_HEADER) begin
                    if (n_byte_index < 4'd3 ||
                        (n_byte_index == 4'd3 && n_tag_shift != wpp_pkg::TAG_RIFF)) begin
                        status_code = wpp_pkg::ST_NOT_RIFF;
                    end else begin
                        status_code = wpp_pkg::ST_NOT_WAVE;
                    end
                end else begin
                    status_code = final_code(n_fmt_found, n_data_found, n_format_tag,
                                             n_channels, n_rate, i_required_rate, n_bits);
                end
            end

            if (emit_status) n_finished = 1'b1;
        end

        // Rearm after the last byte of a file
        if (r_beat_valid && r_eof) begin
            n_phase        = PH_HEADER;
            n_byte_index   = 4'd0;
            n_tag_shift    = 32'd0;
            n_chunk_length = 32'd0;
            n_bytes_left   = 33'd0;
            n_format_tag   = 16'd0;
            n_channels     = 16'd0;
            n_rate         = 32'd0;
            n_bits         = 16'd0;
            n_fmt_found    = 1'b0;
            n_data_found   = 1'b0;
            n_low_byte     = 8'd0;
            n_finished     = 1'b0;
        end
    end

    // Build the result pair: a sample always goes ahead of the status
    always_comb begin : p_pair
        wpp_pkg::t_result smp;
        wpp_pkg::t_result sts;

        smp.result_kind  = wpp_pkg::KIND_SAMPLE;
        smp.sample_value = {r_byte, r_low_byte};
        smp.status_code  = wpp_pkg::ST_OK;
        smp.last_result  = 1'b0;
        sts.result_kind  = wpp_pkg::KIND_STATUS;
        sts.sample_value = 16'sd0;
        sts.status_code  = status_code;
        sts.last_result  = 1'b1;

        o_pair.count = {emit_sample & emit_status, emit_sample ^ emit_status};
        o_pair.r0    = emit_sample ? smp : sts;
        o_pair.r1    = sts;
        o_push       = emit_sample | emit_status;
    end

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_byte_index   <= 4'd0;
            r_tag_shift    <= 32'd0;
            r_chunk_length <= 32'd0;
            r_bytes_left   <= 33'd0;
            r_format_tag   <= 16'd0;
            r_channels     <= 16'd0;
            r_rate         <= 32'd0;
            r_bits         <= 16'd0;
            r_fmt_found    <= 1'b0;
            r_data_found   <= 1'b0;
            r_low_byte     <= 8'd0;
            r_finished     <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_byte_index   <= n_byte_index;
            r_tag_shift    <= n_tag_shift;
            r_chunk_length <= n_chunk_length;
            r_bytes_left   <= n_bytes_left;
            r_format_tag   <= n_format_tag;
            r_channels     <= n_channels;
            r_rate         <= n_rate;
            r_bits         <= n_bits;
            r_fmt_found    <= n_fmt_found;
            r_data_found   <= n_data_found;
            r_low_byte     <= n_low_byte;
            r_finished     <= n_finished;
        end
    end

    // A live data body always has bytes still to come; a closed file may rest in it
    a_data_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA && !r_finished |-> r_bytes_left != 33'd0)
        else $error("data phase with no bytes left");

    // A finished file yields nothing until its end byte
    a_finished_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_beat_valid && r_finished |-> !o_push)
        else $error("result after the final status");

    // A status closes the file unless the same byte rearms it
    a_status_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_beat_valid && emit_status && !r_eof |=> r_finished)
        else $error("status did not close the file");

endmodule

// ===== hw/rtl/wpp_out_queue.sv =====
// Result queue: holds result pairs and hands them out one beat at a time.
// Depends on wpp_pkg and wpp_result_if.
module wpp_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wpp_pkg::t_pair    i_pair,
    wpp_result_if.source      o_out,
    output logic              o_space_ok
);

    wpp_pkg::t_pair                   r_mem [wpp_pkg::OUT_DEPTH];
    logic [wpp_pkg::OUT_PTR_W-1:0]    r_wr_ptr;
    logic [wpp_pkg::OUT_PTR_W-1:0]    r_rd_ptr;
    logic [wpp_pkg::OUT_CNT_W-1:0]    r_count;
    logic [wpp_pkg::OUT_CNT_W-1:0]    n_count;
    logic                             r_sub;
    logic                             n_sub;

    wpp_pkg::t_pair    head;
    wpp_pkg::t_result  cur;
    logic              pop;
    logic              pop_entry;

    assign head = r_mem[r_rd_ptr];
    assign cur  = r_sub ? head.r1 : head.r0;

    // Present the head result
    assign o_out.valid        = r_count != '0;
    assign o_out.result_kind  = cur.result_kind;
    assign o_out.sample_value = cur.sample_value;
    assign o_out.status_code  = cur.status_code;
    assign o_out.last_result  = cur.last_result;

    // Room for the pair in the input register and one more behind it
    assign o_space_ok = r_count <= wpp_pkg::OUT_CNT_W'(wpp_pkg::OUT_DEPTH - 2);

    assign pop       = o_out.valid && o_out.ready;
    assign pop_entry = pop && (r_sub || head.count != 2'd2);

    always_comb begin
        n_count = r_count + {{(wpp_pkg::OUT_CNT_W-1){1'b0}}, i_push}
                          - {{(wpp_pkg::OUT_CNT_W-1){1'b0}}, pop_entry};
        n_sub   = r_sub;
        if (pop) n_sub = !r_sub && head.count == 2'd2;
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_sub    <= 1'b0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop_entry) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= n_count;
            r_sub   <= n_sub;
        end
    end

    // Write storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_pair;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count != wpp_pkg::OUT_CNT_W'(wpp_pkg::OUT_DEPTH))
        else $error("result queue overflow");

    a_sub_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (r_count != '0 && head.count == 2'd2))
        else $error("second result read from a single entry");

endmodule

// ===== tb/tb_wav_pcm_stream_parser.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of wav_pcm_stream_parser: WAV byte streams in, samples and status out.
// Depends on wpp_pkg, the three channel interfaces and the parser RTL.
module tb_wav_pcm_stream_parser;
    import wpp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_BYTES = 30;

    typedef enum logic [2:0] {
        PH_HEADER, PH_CHUNK, PH_FMT, PH_EXCESS, PH_DATA, PH_SKIP
    } t_parse_phase;

    // Tracks the parser state beat by beat and holds the results it owes
    class t_parse_board;
        logic [31:0]  required_rate;
        t_parse_phase phase;
        logic [3:0]   idx;
        logic [31:0]  tag_acc;
        logic [31:0]  chunk_len;
        logic [32:0]  left;
        logic [15:0]  fmt_tag;
        logic [15:0]  chan_cnt;
        logic [31:0]  rate_seen;
        logic [15:0]  bits_seen;
        bit           fmt_got;
        bit           data_got;
        bit           closed;
        logic [7:0]   low_hold;
        t_result      pending_results[$];
        int           errors;
        int           samples_seen;
        int           status_seen[8];

        function new();
            required_rate = RATE_RESET;
            errors = 0;
            samples_seen = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            rearm();
        endfunction

        function void rearm();
            phase = PH_HEADER;
            idx = '0;
            tag_acc = '0;
            chunk_len = '0;
            left = '0;
            fmt_tag = '0;
            chan_cnt = '0;
            rate_seen = '0;
            bits_seen = '0;
            fmt_got = 1'b0;
            data_got = 1'b0;
            low_hold = '0;
            closed = 1'b0;
        endfunction

        function void owe_status(t_status code);
            t_result r;
            r.result_kind = KIND_STATUS;
            r.sample_value = '0;
            r.status_code = code;
            r.last_result = 1'b1;
            pending_results.insert(pending_results.size(), r);
            closed = 1'b1;
        endfunction

        function void owe_sample(logic [15:0] raw);
            t_result r;
            r.result_kind = KIND_SAMPLE;
            r.sample_value = raw;
            r.status_code = ST_OK;
            r.last_result = 1'b0;
            pending_results.insert(pending_results.size(), r);
        endfunction

        // Status order: missing chunk, format, channels, rate, bits
        function t_status file_verdict();
            if (!fmt_got || !data_got) return ST_MISSING;
            if (fmt_tag != FORMAT_PCM) return ST_NOT_PCM;
            if (chan_cnt != MONO) return ST_NOT_MONO;
            if (rate_seen != required_rate) return ST_BAD_RATE;
            if (bits_seen != BITS_16) return ST_NOT_16BIT;
            return ST_OK;
        endfunction

        function void close_chunk();
            if (fmt_got && data_got) begin
                owe_status(file_verdict());
            end else begin
                phase = PH_CHUNK;
                idx = '0;
            end
        endfunction

        function void header_step(logic [7:0] b);
            tag_acc = {tag_acc[23:0], b};
            if (idx == 4'd3 && tag_acc != TAG_RIFF) begin
                owe_status(ST_NOT_RIFF);
            end else if (idx == 4'd11) begin
                if (tag_acc != TAG_WAVE) begin
                    owe_status(ST_NOT_WAVE);
                end else begin
                    phase = PH_CHUNK;
                    idx = '0;
                end
            end else begin
                idx = idx + 4'd1;
            end
        endfunction

        function void chunk_step(logic [7:0] b);
            if (idx < 4'd4) begin
                tag_acc = {tag_acc[23:0], b};
                idx = idx + 4'd1;
            end else begin
                chunk_len = {b, chunk_len[31:8]};
                if (idx < 4'd7) begin
                    idx = idx + 4'd1;
                end else begin
                    idx = '0;
                    if (tag_acc == TAG_FMT) begin
                        fmt_got = 1'b1;
                        phase = PH_FMT;
                    end else if (tag_acc == TAG_DATA) begin
                        data_got = 1'b1;
                        left = {1'b0, chunk_len[31:1], 1'b0};
                        if (left == '0) close_chunk();
                        else phase = PH_DATA;
                    end else begin
                        // Skip the body together with its pad byte
                        left = {1'b0, chunk_len} + {32'd0, chunk_len[0]};
                        if (left == '0) close_chunk();
                        else phase = PH_SKIP;
                    end
                end
            end
        endfunction

        function void fmt_step(logic [7:0] b);
            int i;
            i = int'(idx);
            if (i < 2) fmt_tag[i*8 +: 8] = b;
            else if (i < 4) chan_cnt[(i-2)*8 +: 8] = b;
            else if (i < 8) rate_seen[(i-4)*8 +: 8] = b;
            else if (i >= 14) bits_seen[(i-14)*8 +: 8] = b;
            if (i < 15) begin
                idx = idx + 4'd1;
            end else begin
                idx = '0;
                if (chunk_len > FMT_BODY) begin
                    left = {1'b0, chunk_len - FMT_BODY};
                    phase = PH_EXCESS;
                end else begin
                    close_chunk();
                end
            end
        endfunction

        function void parse_byte(logic [7:0] b);
            case (phase)
                PH_HEADER: header_step(b);
                PH_CHUNK:  chunk_step(b);
                PH_FMT:    fmt_step(b);
                PH_DATA: begin
                    if (idx[0] == 1'b0) begin
                        low_hold = b;
                        idx = 4'd1;
                    end else begin
                        owe_sample({b, low_hold});
                        idx = '0;
                    end
                    if (left != '0) left = left - 33'd1;
                    if (left == '0) close_chunk();
                end
                default: begin
                    if (left != '0) left = left - 33'd1;
                    if (left == '0) close_chunk();
                end
            endcase
        endfunction

        // Note one accepted beat; return 1 unless the parser drops it
        function bit note_byte(logic [7:0] b, bit eof);
            bit live;
            live = !closed;
            if (!closed) begin
                parse_byte(b);
                if (eof && !closed) begin
                    if (phase != PH_HEADER) owe_status(file_verdict());
                    else if (idx < 4'd3 || (idx == 4'd3 && tag_acc != TAG_RIFF))
                        owe_status(ST_NOT_RIFF);
                    else owe_status(ST_NOT_WAVE);
                end
            end
            if (eof) rearm();
            return live;
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with none due: kind=%0d sample=%0d status=%0d last=%0d",
                         $time, got.result_kind, got.sample_value, got.status_code,
                         got.last_result);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (want.result_kind == KIND_SAMPLE) samples_seen++;
            else status_seen[want.status_code]++;
            if (got.result_kind !== want.result_kind) begin
                $display("%0t: result_kind expected %0d actual %0d",
                         $time, want.result_kind, got.result_kind);
                errors++;
            end
            if (got.sample_value !== want.sample_value) begin
                $display("%0t: sample_value expected %0d actual %0d",
                         $time, want.sample_value, got.sample_value);
                errors++;
            end
            if (got.status_code !== want.status_code) begin
                $display("%0t: status_code expected %0d actual %0d",
                         $time, want.status_code, got.status_code);
                errors++;
            end
            if (got.last_result !== want.last_result) begin
                $display("%0t: last_result expected %0d actual %0d",
                         $time, want.last_result, got.last_result);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm = 1'b0;
    bit   hold_request = 1'b0;
    int   bytes_sent = 0;
    int   live_bytes = 0;
    int   files_sent = 0;
    int   rate_settings = 1;
    logic [7:0] file_bytes[$];
    t_parse_board sb;

    wpp_cfg_if    cfg_if();
    wpp_byte_if   in_if();
    wpp_result_if out_if();

    wav_pcm_stream_parser dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hand out one beat; idle at random first unless the run is calm
    task automatic send_byte(input logic [7:0] b, input bit eof);
        while (!calm && $urandom_range(99) < 9) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data_byte <= b;
        in_if.end_of_file <= eof;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        bytes_sent++;
        if (sb.note_byte(b, eof)) live_bytes++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        files_sent++;
    endtask

    task automatic in_quiet();
        in_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drain();
        while (sb.pending_results.size() != 0) @(posedge clk);
    endtask

    // Write the rate only once the parser has gone idle
    task automatic write_rate(input logic [31:0] v);
        in_quiet();
        wait_drain();
        repeat (SETTLE) @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.wr_data <= v;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        sb.required_rate = v;
        rate_settings++;
        cfg_if.valid <= 1'b0;
    endtask

    function automatic void add_byte(input logic [7:0] b);
        file_bytes.insert(file_bytes.size(), b);
    endfunction

    function automatic void push_tag(input logic [31:0] t);
        for (int i = 3; i >= 0; i--) add_byte(t[i*8 +: 8]);
    endfunction

    function automatic void push_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) add_byte(v[i*8 +: 8]);
    endfunction

    function automatic void push_junk();
        int size;
        size = $urandom_range(5);
        push_le($urandom, 4);
        push_le(32'(size), 4);
        repeat (size + size % 2) add_byte(8'($urandom_range(255)));
    endfunction

    // Mostly well-formed fields, now and then a bad one
    function automatic void push_fmt();
        int sel;
        int size;
        sel = $urandom_range(7);
        if (sel < 5) size = 16;
        else if (sel < 7) size = $urandom_range(17, 20);
        else size = $urandom_range(15);
        push_tag(TAG_FMT);
        push_le(32'(size), 4);
        push_le(($urandom_range(9) == 0) ? $urandom : {16'd0, FORMAT_PCM}, 2);
        push_le(($urandom_range(9) == 0) ? $urandom : {16'd0, MONO}, 2);
        push_le(($urandom_range(6) == 0) ? $urandom : sb.required_rate, 4);
        push_le($urandom, 4);
        push_le($urandom, 2);
        push_le(($urandom_range(9) == 0) ? $urandom : {16'd0, BITS_16}, 2);
        repeat ((size > 16) ? size - 16 : 0) add_byte(8'($urandom_range(255)));
    endfunction

    function automatic void push_data();
        int dlen;
        int pick;
        logic [15:0] s;
        dlen = ($urandom_range(7) == 0) ? $urandom_range(1) : $urandom_range(2, 24);
        push_tag(TAG_DATA);
        push_le(32'(dlen), 4);
        repeat (dlen / 2) begin
            pick = $urandom_range(7);
            case (pick)
                0: s = 16'h8000;
                1: s = 16'h7FFF;
                2: s = 16'h0000;
                3: s = 16'hFFFF;
                default: s = 16'($urandom);
            endcase
            push_le({16'd0, s}, 2);
        end
    endfunction

    function automatic void build_wave();
        int order;
        int cut;
        file_bytes.delete();
        push_tag(($urandom_range(49) == 0) ? $urandom : TAG_RIFF);
        push_le($urandom, 4);
        push_tag(($urandom_range(49) == 0) ? $urandom : TAG_WAVE);
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) push_junk();
        order = $urandom_range(19);
        if (order < 16) begin
            push_fmt();
            if ($urandom_range(4) == 0) push_junk();
            push_data();
        end else if (order < 19) begin
            push_data();
            push_fmt();
        end else if ($urandom_range(1) == 0) begin
            push_fmt();
        end else begin
            push_data();
        end
        // Trailing bytes are dropped when they land after the final status
        repeat ($urandom_range(3)) add_byte(8'($urandom_range(255)));
        if ($urandom_range(9) == 0) begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end
        if ($urandom_range(19) == 0)
            file_bytes[$urandom_range(file_bytes.size() - 1)] = 8'($urandom_range(255));
    endfunction

    function automatic void build_noise();
        file_bytes.delete();
        if ($urandom_range(1) == 0) push_tag(TAG_RIFF);
        repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(255)));
    endfunction

    task automatic run_random(input int target);
        int start;
        start = live_bytes;
        while (live_bytes - start < target) begin
            if ($urandom_range(9) < 8) build_wave();
            else build_noise();
            send_file();
        end
    endtask

    // Short broken files: both header errors and end of file inside or right after the RIFF tag
    task automatic run_directed();
        file_bytes = '{8'h00};
        send_file();
        file_bytes = '{8'hFF};
        send_file();
        file_bytes = '{8'h52, 8'h49, 8'h46};
        send_file();
        file_bytes = '{8'h52, 8'h49, 8'h46, 8'h58};
        send_file();
        file_bytes = '{8'h52, 8'h49, 8'h46, 8'h46};
        send_file();
        file_bytes = '{8'h52, 8'h49, 8'h46, 8'h46, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                       8'h57, 8'h41, 8'h56, 8'h58};
        send_file();
    endtask

    // Take results; hold ready low for a long stretch when asked
    initial begin : result_sink
        int hold_left;
        t_result seen;
        hold_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_if.valid && out_if.ready) begin
                seen.result_kind = out_if.result_kind;
                seen.sample_value = out_if.sample_value;
                seen.status_code = out_if.status_code;
                seen.last_result = out_if.last_result;
                sb.check_result(seen);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (!rst_n || hold_left > 0) begin
                out_if.ready <= 1'b0;
                if (hold_left > 0) hold_left--;
            end else begin
                out_if.ready <= calm || ($urandom_range(99) >= 9);
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_wav_pcm_stream_parser NOT OK");
        $finish;
    end

    initial begin : stimulus
        sb = new();
        rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.data_byte <= '0;
        in_if.end_of_file <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.wr_data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random(PHASE_BYTES);

        write_rate(32'd0);
        run_random(PHASE_BYTES);

        // Stall the result side while bytes keep coming
        write_rate(32'hFFFF_FFFF);
        hold_request = 1'b1;
        run_random(PHASE_BYTES);

        // No idling here; pause mid-phase until all results are in
        write_rate(32'd44100);
        calm = 1'b1;
        run_random(PHASE_BYTES / 2);
        in_quiet();
        wait_drain();
        run_random(PHASE_BYTES / 2);
        calm = 1'b0;

        write_rate(RATE_RESET);
        run_random(PHASE_BYTES);

        write_rate($urandom);
        run_random(PHASE_BYTES);

        in_quiet();
        wait_drain();
        repeat (20) @(posedge clk);

        $display("Run: %0d files, %0d bytes (%0d parsed), %0d samples, %0d rate settings",
                 files_sent, bytes_sent, live_bytes, sb.samples_seen, rate_settings);
        $display("Statuses: ok %0d, riff %0d, wave %0d, missing %0d,",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
        $display("          pcm %0d, mono %0d, rate %0d, bits %0d",
                 sb.status_seen[4], sb.status_seen[5], sb.status_seen[6], sb.status_seen[7]);
        if (sb.errors == 0) begin
            $display("tb_wav_pcm_stream_parser OK");
        end else begin
            $display("tb_wav_pcm_stream_parser NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/wpp_pkg.sv
hw/rtl/wpp_byte_if.sv
hw/rtl/wpp_result_if.sv
hw/rtl/wpp_cfg_if.sv
hw/rtl/wpp_parser.sv
hw/rtl/wpp_out_queue.sv
hw/rtl/wav_pcm_stream_parser.sv
tb/tb_wav_pcm_stream_parser.sv
